@@ hdl/assert_macros.svh @@
// Assertion macros used by the top-level RTL module of the leader election block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cle_pkg.sv @@
// Types, codes and reset constants of the leader election block.
package cle_pkg;

    localparam int TERM_W  = 32;
    localparam int ID_W    = 4;
    localparam int COUNT_W = 5;
    localparam int TIMER_W = 16;
    localparam int CD_W    = 17;
    localparam int JIT_W   = 7;
    localparam int ROLE_W  = 2;
    localparam int KIND_W  = 2;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [ROLE_W-1:0] ROLE_FOLLOWER  = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_CANDIDATE = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_LEADER    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BEAT    = 2'd3;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REPLY   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BEAT    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELF_ID          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOLLOWER_WAIT    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_PERIOD = 2'd3;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET       = 5'd1;
    localparam logic [ID_W-1:0]    SELF_ID_RESET          = 4'd0;
    localparam logic [TIMER_W-1:0] FOLLOWER_WAIT_RESET    = 16'd200;
    localparam logic [TIMER_W-1:0] BROADCAST_PERIOD_RESET = 16'd20;

    localparam logic [JIT_W-1:0]   JITTER_SPAN = 7'd100;
    localparam logic [COUNT_W-1:0] VOTES_MAX   = 5'd31;
    localparam logic [TERM_W-1:0]  TERM_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [COUNT_W-1:0] node_count;
        logic [ID_W-1:0]    self_id;
        logic [TIMER_W-1:0] follower_wait;
        logic [TIMER_W-1:0] broadcast_period;
    } cfg_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [TERM_W-1:0] msg_term;
        logic [ID_W-1:0]   msg_node;
        logic [JIT_W-1:0]  jitter;
    } item_t;

    typedef struct packed {
        logic [ROLE_W-1:0]  role;
        logic [TERM_W-1:0]  term;
        logic [ID_W-1:0]    leader;
        logic               leader_known;
        logic [COUNT_W-1:0] votes;
        logic               heard_beat;
        logic [CD_W-1:0]    countdown;
    } node_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] send_kind;
        logic [TERM_W-1:0] send_term;
        logic [ID_W-1:0]   send_node;
        logic [ROLE_W-1:0] role_now;
        logic [ID_W-1:0]   leader_now;
        logic              leader_valid;
    } result_t;

endpackage

@@ hdl/consensus_leader_election_fsm.sv @@
// Top level of the leader election block: registers, handshakes and configuration.
//
//   Channel   Direction  Handshake             Contents
//   in        input      in_valid / in_ready   command, msg_term, msg_node, jitter
//   out       output     out_valid / out_ready one result per event
//   cfg       input      cfg_wr_en             cfg_index, cfg_data
//
// An event is captured in an input register, and its result is registered in the
// output register when that register is empty or its result is being taken.
// One event is accepted in every cycle while the output side takes results.
// The election state is updated in the same cycle the result is registered.
// When the output register is held, the input register fills and in_ready drops.
// Reset clears the election state and loads the configuration defaults.
module consensus_leader_election_fsm
    import cle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [TERM_W-1:0]     msg_term,
    input  logic [ID_W-1:0]       msg_node,
    input  logic [JIT_W-1:0]      jitter,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     send_kind,
    output logic [TERM_W-1:0]     send_term,
    output logic [ID_W-1:0]       send_node,
    output logic [ROLE_W-1:0]     role_now,
    output logic [ID_W-1:0]       leader_now,
    output logic                  leader_valid,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

    cfg_t        cfg_reg;
    item_t       stage_item_reg;
    logic        stage_valid_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    node_state_t state_reg;
    node_state_t state_next;
    logic        advance;

    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;

    cle_step u_step
    (
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .item (stage_item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_count       <= NODE_COUNT_RESET;
            cfg_reg.self_id          <= SELF_ID_RESET;
            cfg_reg.follower_wait    <= FOLLOWER_WAIT_RESET;
            cfg_reg.broadcast_period <= BROADCAST_PERIOD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_NODE_COUNT:       cfg_reg.node_count       <= cfg_data[COUNT_W-1:0];
                REG_SELF_ID:          cfg_reg.self_id          <= cfg_data[ID_W-1:0];
                REG_FOLLOWER_WAIT:    cfg_reg.follower_wait    <= cfg_data[TIMER_W-1:0];
                REG_BROADCAST_PERIOD: cfg_reg.broadcast_period <= cfg_data[TIMER_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= '{role: ROLE_FOLLOWER, term: '0, leader: '0,
                                 leader_known: 1'b0, votes: '0, heard_beat: 1'b0,
                                 countdown: {1'b0, FOLLOWER_WAIT_RESET}};
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                stage_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= '{command: command, msg_term: msg_term,
                                msg_node: msg_node, jitter: jitter};
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign send_kind    = result_reg.send_kind;
    assign send_term    = result_reg.send_term;
    assign send_node    = result_reg.send_node;
    assign role_now     = result_reg.role_now;
    assign leader_now   = result_reg.leader_now;
    assign leader_valid = result_reg.leader_valid;

    // The term never moves backward, whatever the event.
    `ASSERT_NEXT(a_term_monotonic, 1'b1, state_reg.term >= $past(state_reg.term),
        "term decreased")
    // A transaction that sends nothing carries no term and no sender.
    `ASSERT_SAME(a_quiet_result, out_valid_reg && result_reg.send_kind == KIND_NONE,
        result_reg.send_term == '0 && result_reg.send_node == '0,
        "empty result carries a term or sender")
    // Vote requests come only from a candidate, heartbeats only from a leader.
    `ASSERT_SAME(a_request_role, out_valid_reg && result_reg.send_kind == KIND_REQUEST,
        result_reg.role_now == ROLE_CANDIDATE, "vote request sent outside candidacy")
    `ASSERT_SAME(a_beat_role, out_valid_reg && result_reg.send_kind == KIND_BEAT,
        result_reg.role_now == ROLE_LEADER, "heartbeat sent by a non-leader")
    // Input back-pressure appears only when both registers are occupied and held.
    `ASSERT_SAME(a_stall_cause, !in_ready,
        stage_valid_reg && out_valid_reg && !out_ready, "input stalled without cause")

endmodule

@@ hdl/cle_step.sv @@
// Next-state and result logic for one event of the leader election machine.
module cle_step
    import cle_pkg::*;
(
    input  cfg_t        cfg,
    input  node_state_t cur,
    input  item_t       item,
    output node_state_t nxt,
    output result_t     res
);

    logic [ROLE_W-1:0]  role_cur;
    logic [KIND_W-1:0]  kind;
    logic [JIT_W-1:0]   jit_mod;
    logic [COUNT_W-1:0] votes_inc;
    logic [COUNT_W-1:0] majority;
    logic [TERM_W-1:0]  term_bump;
    logic               solo;
    logic               beat_ok;

    always_comb
    begin
        role_cur  = (cur.role > ROLE_LEADER) ? ROLE_FOLLOWER : cur.role;
        jit_mod   = (item.jitter >= JITTER_SPAN) ? (item.jitter - JITTER_SPAN) : item.jitter;
        votes_inc = (cur.votes != VOTES_MAX) ? (cur.votes + COUNT_W'(1)) : cur.votes;
        majority  = {1'b0, cfg.node_count[COUNT_W-1:1]} + COUNT_W'(1);
        term_bump = (cur.term != TERM_MAX) ? (cur.term + TERM_W'(1)) : cur.term;
        solo      = (cfg.node_count <= COUNT_W'(1));
        beat_ok   = (role_cur == ROLE_LEADER) ? (item.msg_term > cur.term)
                                              : (item.msg_term >= cur.term);
        nxt       = cur;
        nxt.role  = role_cur;
        kind      = KIND_NONE;

        case (item.command)
            CMD_REQUEST:
            begin
                if (item.msg_term > cur.term)
                begin
                    nxt.term = item.msg_term;
                    kind     = KIND_REPLY;
                    if (role_cur != ROLE_FOLLOWER)
                    begin
                        nxt.role      = ROLE_FOLLOWER;
                        nxt.countdown = {1'b0, cfg.follower_wait};
                    end
                end
            end
            CMD_REPLY:
            begin
                if (role_cur == ROLE_CANDIDATE && item.msg_term == cur.term)
                begin
                    nxt.votes = votes_inc;
                    if (votes_inc >= majority)
                    begin
                        nxt.role      = ROLE_LEADER;
                        nxt.countdown = {1'b0, cfg.broadcast_period};
                    end
                end
            end
            CMD_BEAT:
            begin
                if (beat_ok)
                begin
                    nxt.term         = item.msg_term;
                    nxt.leader       = item.msg_node;
                    nxt.leader_known = 1'b1;
                    if (role_cur == ROLE_FOLLOWER)
                    begin
                        nxt.heard_beat = 1'b1;
                    end
                    else
                    begin
                        nxt.role      = ROLE_FOLLOWER;
                        nxt.countdown = {1'b0, cfg.follower_wait};
                    end
                end
            end
            default:
            begin
                if (cur.countdown > CD_W'(1))
                begin
                    nxt.countdown = cur.countdown - CD_W'(1);
                end
                else if (role_cur == ROLE_FOLLOWER && cur.heard_beat)
                begin
                    nxt.heard_beat = 1'b0;
                    nxt.countdown  = {1'b0, cfg.follower_wait};
                end
                else if (role_cur == ROLE_LEADER)
                begin
                    kind          = KIND_BEAT;
                    nxt.countdown = {1'b0, cfg.broadcast_period};
                end
                else if (solo)
                begin
                    nxt.role      = ROLE_LEADER;
                    nxt.countdown = {1'b0, cfg.broadcast_period};
                end
                else
                begin
                    kind          = KIND_REQUEST;
                    nxt.role      = ROLE_CANDIDATE;
                    nxt.votes     = COUNT_W'(1);
                    nxt.term      = term_bump;
                    nxt.countdown = {1'b0, cfg.follower_wait} + CD_W'(jit_mod);
                end
            end
        endcase

        res.send_kind    = kind;
        res.send_term    = (kind == KIND_NONE) ? '0 : nxt.term;
        res.send_node    = (kind inside {KIND_REQUEST, KIND_BEAT}) ? cfg.self_id : '0;
        res.role_now     = nxt.role;
        res.leader_now   = nxt.leader;
        res.leader_valid = nxt.leader_known;
    end

endmodule

@@ verif/tb_consensus_leader_election_fsm.sv @@
// Self-checking testbench for the leader election block with a built-in election predictor.
module tb_consensus_leader_election_fsm
    import cle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 64;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [CMD_W-1:0]      command = CMD_TICK;
    logic [TERM_W-1:0]     msg_term = '0;
    logic [ID_W-1:0]       msg_node = '0;
    logic [JIT_W-1:0]      jitter = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [KIND_W-1:0]     send_kind;
    logic [TERM_W-1:0]     send_term;
    logic [ID_W-1:0]       send_node;
    logic [ROLE_W-1:0]     role_now;
    logic [ID_W-1:0]       leader_now;
    logic                  leader_valid;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cfg_t        shadow_cfg;
    node_state_t shadow_node;
    result_t     pending_results[$];
    result_t     oldest;

    int          fail_count = 0;
    int          cycle_count = 0;
    bit          src_paced = 1'b0;
    bit          sink_paced = 1'b0;
    int unsigned hold_reqs = 0;
    int unsigned holds_done = 0;
    int unsigned hold_left = 0;
    int unsigned stall_left = 0;

    consensus_leader_election_fsm uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .msg_term     (msg_term),
        .msg_node     (msg_node),
        .jitter       (jitter),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .send_kind    (send_kind),
        .send_term    (send_term),
        .send_node    (send_node),
        .role_now     (role_now),
        .leader_now   (leader_now),
        .leader_valid (leader_valid),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void promote();
        shadow_node.role = ROLE_LEADER;
        shadow_node.countdown = CD_W'(shadow_cfg.broadcast_period);
    endfunction

    function automatic void demote();
        shadow_node.role = ROLE_FOLLOWER;
        shadow_node.countdown = CD_W'(shadow_cfg.follower_wait);
    endfunction

    function automatic logic [KIND_W-1:0] begin_candidacy(logic [JIT_W-1:0] jit);
        if (shadow_cfg.node_count <= 1)
        begin
            promote();
            return KIND_NONE;
        end
        shadow_node.role = ROLE_CANDIDATE;
        shadow_node.votes = COUNT_W'(1);
        if (shadow_node.term != TERM_MAX)
            shadow_node.term = shadow_node.term + TERM_W'(1);
        shadow_node.countdown = CD_W'(shadow_cfg.follower_wait) + CD_W'(jit % JITTER_SPAN);
        return KIND_REQUEST;
    endfunction

    function automatic result_t elect_step(item_t ev);
        result_t           r;
        logic [KIND_W-1:0] kind;
        logic              take;
        kind = KIND_NONE;
        if (shadow_node.role > ROLE_LEADER)
            shadow_node.role = ROLE_FOLLOWER;
        case (ev.command)
            CMD_REQUEST:
            begin
                if (ev.msg_term > shadow_node.term)
                begin
                    shadow_node.term = ev.msg_term;
                    kind = KIND_REPLY;
                    if (shadow_node.role != ROLE_FOLLOWER)
                        demote();
                end
            end
            CMD_REPLY:
            begin
                if (shadow_node.role == ROLE_CANDIDATE && ev.msg_term == shadow_node.term)
                begin
                    if (shadow_node.votes < VOTES_MAX)
                        shadow_node.votes = shadow_node.votes + COUNT_W'(1);
                    if (int'(shadow_node.votes) >= int'(shadow_cfg.node_count) / 2 + 1)
                        promote();
                end
            end
            CMD_BEAT:
            begin
                take = (shadow_node.role == ROLE_LEADER) ? (ev.msg_term > shadow_node.term)
                                                         : (ev.msg_term >= shadow_node.term);
                if (take)
                begin
                    shadow_node.term = ev.msg_term;
                    shadow_node.leader = ev.msg_node;
                    shadow_node.leader_known = 1'b1;
                    if (shadow_node.role == ROLE_FOLLOWER)
                        shadow_node.heard_beat = 1'b1;
                    else
                        demote();
                end
            end
            default:
            begin
                if (shadow_node.countdown > 1)
                    shadow_node.countdown = shadow_node.countdown - CD_W'(1);
                else if (shadow_node.role == ROLE_FOLLOWER)
                begin
                    if (shadow_node.heard_beat)
                    begin
                        shadow_node.heard_beat = 1'b0;
                        shadow_node.countdown = CD_W'(shadow_cfg.follower_wait);
                    end
                    else
                        kind = begin_candidacy(ev.jitter);
                end
                else if (shadow_node.role == ROLE_CANDIDATE)
                    kind = begin_candidacy(ev.jitter);
                else
                begin
                    kind = KIND_BEAT;
                    shadow_node.countdown = CD_W'(shadow_cfg.broadcast_period);
                end
            end
        endcase
        r.send_kind = kind;
        r.send_term = (kind == KIND_NONE) ? '0 : shadow_node.term;
        r.send_node = (kind == KIND_REQUEST || kind == KIND_BEAT) ? shadow_cfg.self_id : '0;
        r.role_now = shadow_node.role;
        r.leader_now = shadow_node.leader;
        r.leader_valid = shadow_node.leader_known;
        return r;
    endfunction

    function automatic item_t mk_msg(logic [CMD_W-1:0] c, logic [TERM_W-1:0] t,
                                     logic [ID_W-1:0] n, logic [JIT_W-1:0] j);
        item_t ev;
        ev.command = c;
        ev.msg_term = t;
        ev.msg_node = n;
        ev.jitter = j;
        return ev;
    endfunction

    // Mostly plausible traffic for the current role, with terms close to the node's own.
    function automatic item_t pick_msg();
        item_t       ev;
        int unsigned roll;
        int unsigned t_req;
        int unsigned t_rep;
        int unsigned t_beat;
        case (shadow_node.role)
            ROLE_CANDIDATE:
            begin
                t_req = 10;
                t_rep = 60;
                t_beat = 70;
            end
            ROLE_LEADER:
            begin
                t_req = 15;
                t_rep = 25;
                t_beat = 40;
            end
            default:
            begin
                t_req = 15;
                t_rep = 25;
                t_beat = 45;
            end
        endcase
        roll = $urandom_range(99, 0);
        if (roll < t_req)
            ev.command = CMD_REQUEST;
        else if (roll < t_rep)
            ev.command = CMD_REPLY;
        else if (roll < t_beat)
            ev.command = CMD_BEAT;
        else
            ev.command = CMD_TICK;
        roll = $urandom_range(99, 0);
        if (roll < 5)
            ev.msg_term = $urandom;
        else if (roll < 8)
            ev.msg_term = TERM_MAX - $urandom_range(2, 0);
        else if (ev.command == CMD_REPLY && roll < 75)
            ev.msg_term = shadow_node.term;
        else
            ev.msg_term = shadow_node.term + $urandom_range(3, 0) - 1;
        ev.msg_node = ID_W'($urandom_range(15, 0));
        ev.jitter = JIT_W'($urandom_range(127, 0));
        return ev;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (!src_paced)
            return 0;
        roll = $urandom_range(99, 0);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(3, 1);
        return $urandom_range(25, 8);
    endfunction

    task automatic report_mismatch(string field, logic [TERM_W-1:0] got,
                                   logic [TERM_W-1:0] want);
        if (fail_count < 50)
            $display("ERROR: %s got 0x%0h, expected 0x%0h", field, got, want);
        fail_count++;
    endtask

    task automatic send_msg(item_t ev);
        int unsigned gap;
        in_valid <= 1'b1;
        command <= ev.command;
        msg_term <= ev.msg_term;
        msg_node <= ev.msg_node;
        jitter <= ev.jitter;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.insert(pending_results.size(), elect_step(ev));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_NODE_COUNT:    shadow_cfg.node_count = data[COUNT_W-1:0];
            REG_SELF_ID:       shadow_cfg.self_id = data[ID_W-1:0];
            REG_FOLLOWER_WAIT: shadow_cfg.follower_wait = data;
            default:           shadow_cfg.broadcast_period = data;
        endcase
    endtask

    task automatic configure(logic [COUNT_W-1:0] nodes, logic [ID_W-1:0] id,
                             logic [TIMER_W-1:0] timeout, logic [TIMER_W-1:0] period);
        wait_idle();
        write_reg(REG_NODE_COUNT, {11'($urandom), nodes});
        write_reg(REG_SELF_ID, {12'($urandom), id});
        write_reg(REG_FOLLOWER_WAIT, timeout);
        write_reg(REG_BROADCAST_PERIOD, period);
        cfg_wr_en <= 1'b0;
    endtask

    // The single-node cluster elects itself once the reset timer runs out.
    task automatic test_reset_defaults();
        src_paced = 1'b0;
        sink_paced = 1'b1;
        send_msg(mk_msg(CMD_REQUEST, '0, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_REPLY, '0, 4'd0, 7'd0));
        repeat (220) send_msg(mk_msg(CMD_TICK, $urandom, 4'($urandom), 7'($urandom)));
    endtask

    task automatic test_directed();
        configure(5'd3, 4'd15, 16'd1, 16'd1);
        src_paced = 1'b1;
        sink_paced = 1'b1;
        send_msg(mk_msg(CMD_BEAT, '0, 4'd3, 7'd0));
        send_msg(mk_msg(CMD_BEAT, 32'd1, 4'd15, 7'd0));
        send_msg(mk_msg(CMD_TICK, '0, 4'd0, 7'd100));
        send_msg(mk_msg(CMD_REPLY, 32'd1, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_REPLY, 32'd2, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_REPLY, 32'd2, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_TICK, TERM_MAX, 4'd15, 7'd127));
        send_msg(mk_msg(CMD_REQUEST, 32'd2, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_REQUEST, TERM_MAX, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_TICK, '0, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_TICK, '0, 4'd0, 7'd127));
        send_msg(mk_msg(CMD_BEAT, TERM_MAX, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_BEAT, TERM_MAX, 4'd9, 7'd0));
        send_msg(mk_msg(CMD_TICK, '0, 4'd0, 7'd99));
        send_msg(mk_msg(CMD_TICK, '0, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_REQUEST, '0, 4'd0, 7'd0));
        send_msg(mk_msg(CMD_BEAT, '0, 4'd6, 7'd0));
        send_msg(mk_msg(CMD_REPLY, TERM_MAX, 4'd0, 7'd0));
    endtask

    task automatic test_backpressure();
        configure(5'd3, 4'd5, 16'd3, 16'd2);
        src_paced = 1'b0;
        sink_paced = 1'b0;
        hold_reqs++;
        repeat (40) send_msg(pick_msg());
        wait_idle();
        src_paced = 1'b1;
        sink_paced = 1'b1;
        repeat (30) send_msg(pick_msg());
    endtask

    task automatic test_random_phases();
        logic [COUNT_W-1:0] nodes_set[10] = '{3, 2, 5, 16, 0, 1, 31, 4, 7, 3};
        logic [ID_W-1:0]    id_set[10] = '{7, 15, 0, 9, 4, 12, 3, 10, 6, 15};
        logic [TIMER_W-1:0] timeout_set[10] = '{4, 1, 0, 6, 3, 2, 5, 1, 3, 16'hFFFF};
        logic [TIMER_W-1:0] period_set[10] = '{3, 1, 0, 2, 5, 4, 2, 0, 1, 16'hFFFF};
        int                 count;
        for (int p = 0; p < 10; p++)
        begin
            configure(nodes_set[p], id_set[p], timeout_set[p], period_set[p]);
            src_paced = (p % 3 != 0);
            sink_paced = (p % 3 != 0);
            count = (p == 9) ? 60 : 90;
            repeat (count) send_msg(pick_msg());
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_reqs != holds_done)
        begin
            holds_done <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (!sink_paced)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(99, 0) < 70)
            out_ready <= 1'b1;
        else
        begin
            out_ready <= 1'b0;
            stall_left <= ($urandom_range(99, 0) < 12) ? $urandom_range(25, 10)
                                                       : $urandom_range(2, 0);
        end
    end

    // Every result transaction is compared with the oldest predicted one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, send_kind", TERM_W'(send_kind), '0);
            else
            begin
                oldest = pending_results.pop_front();
                if (send_kind !== oldest.send_kind)
                    report_mismatch("send_kind", TERM_W'(send_kind),
                                    TERM_W'(oldest.send_kind));
                if (send_term !== oldest.send_term)
                    report_mismatch("send_term", send_term, oldest.send_term);
                if (send_node !== oldest.send_node)
                    report_mismatch("send_node", TERM_W'(send_node),
                                    TERM_W'(oldest.send_node));
                if (role_now !== oldest.role_now)
                    report_mismatch("role_now", TERM_W'(role_now), TERM_W'(oldest.role_now));
                if (leader_now !== oldest.leader_now)
                    report_mismatch("leader_now", TERM_W'(leader_now),
                                    TERM_W'(oldest.leader_now));
                if (leader_valid !== oldest.leader_valid)
                    report_mismatch("leader_valid", TERM_W'(leader_valid),
                                    TERM_W'(oldest.leader_valid));
            end
        end
    end

    initial
    begin
        shadow_cfg.node_count = NODE_COUNT_RESET;
        shadow_cfg.self_id = SELF_ID_RESET;
        shadow_cfg.follower_wait = FOLLOWER_WAIT_RESET;
        shadow_cfg.broadcast_period = BROADCAST_PERIOD_RESET;
        shadow_node = '0;
        shadow_node.role = ROLE_FOLLOWER;
        shadow_node.countdown = CD_W'(FOLLOWER_WAIT_RESET);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_backpressure();
        test_random_phases();
        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cle_pkg.sv
hdl/cle_step.sv
hdl/consensus_leader_election_fsm.sv
verif/tb_consensus_leader_election_fsm.sv
